>>> rtl/core/bfg_pkg.sv
`default_nettype none

package bfg_pkg;

   localparam int WINDOW_MAX   = 10;
   localparam int SAMPLES_MAX  = 9;
   localparam int CURVE_POINTS = 21;

   localparam int SAMPLE_W   = 12;
   localparam int SUM_W      = 16;
   localparam int CNT_W      = 4;
   localparam int WIN_IDX_W  = $clog2(WINDOW_MAX);
   localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
   localparam int WSUM_W     = SUM_W + FILL_W;
   localparam int DIV_W      = 40;
   localparam int DVSR_W     = 18;
   localparam int SEG_W      = $clog2(CURVE_POINTS);
   localparam int MV_W       = 13;
   localparam int PCT_W      = 7;
   localparam int EMA_W      = 24;
   localparam int NORM_W     = 21;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] REG_DIVIDER   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CAL_SCALE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CAL_OFS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EMPTY     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FULL      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_THR   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES   = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_WINDOW    = 3'd7;

   localparam logic [1:0] SEL_RAW    = 2'd0;
   localparam logic [1:0] SEL_AVG    = 2'd1;
   localparam logic [1:0] SEL_CURVE  = 2'd2;
   localparam logic [1:0] SEL_INTERP = 2'd3;

   typedef struct packed {
      logic       accum;
      logic       mul1;
      logic       mul2;
      logic       div_start;
      logic [1:0] div_sel;
      logic       take_raw;
      logic       win_write;
      logic       sum_step;
      logic       ema_mul;
      logic       ema_update;
      logic       take_num;
      logic       take_norm;
      logic       walk;
      logic       take_map;
      logic       finish;
   } cmd_type;

   typedef struct packed {
      logic last_sample;
      logic div_done;
      logic sum_last;
      logic walk_done;
      logic walk_interp;
   } status_type;

   function automatic logic [MV_W-1:0] curve_mv(input logic [SEG_W-1:0] idx);
      logic [MV_W-1:0] v;
      case (idx)
         5'd0:    v = 13'd4200;
         5'd1:    v = 13'd4150;
         5'd2:    v = 13'd4110;
         5'd3:    v = 13'd4080;
         5'd4:    v = 13'd4020;
         5'd5:    v = 13'd3980;
         5'd6:    v = 13'd3950;
         5'd7:    v = 13'd3910;
         5'd8:    v = 13'd3870;
         5'd9:    v = 13'd3850;
         5'd10:   v = 13'd3840;
         5'd11:   v = 13'd3820;
         5'd12:   v = 13'd3800;
         5'd13:   v = 13'd3790;
         5'd14:   v = 13'd3770;
         5'd15:   v = 13'd3750;
         5'd16:   v = 13'd3730;
         5'd17:   v = 13'd3710;
         5'd18:   v = 13'd3690;
         5'd19:   v = 13'd3610;
         5'd20:   v = 13'd3300;
         default: v = 13'd0;
      endcase
      return v;
   endfunction

   function automatic logic [PCT_W-1:0] curve_pct(input logic [SEG_W-1:0] idx);
      logic [PCT_W-1:0] v;
      case (idx)
         5'd0:    v = 7'd100;
         5'd1:    v = 7'd95;
         5'd2:    v = 7'd90;
         5'd3:    v = 7'd85;
         5'd4:    v = 7'd80;
         5'd5:    v = 7'd75;
         5'd6:    v = 7'd70;
         5'd7:    v = 7'd65;
         5'd8:    v = 7'd60;
         5'd9:    v = 7'd55;
         5'd10:   v = 7'd50;
         5'd11:   v = 7'd45;
         5'd12:   v = 7'd40;
         5'd13:   v = 7'd35;
         5'd14:   v = 7'd30;
         5'd15:   v = 7'd25;
         5'd16:   v = 7'd20;
         5'd17:   v = 7'd15;
         5'd18:   v = 7'd10;
         5'd19:   v = 7'd5;
         default: v = 7'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/bfg_divider.sv
`default_nettype none

module bfg_divider
   import bfg_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [DVSR_W-1:0] divisor,
   output logic                   done,
   output logic [DIV_W-1:0]       quotient
);

   localparam int CNTD_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DVSR_W-1:0] rem_ff, rem_in;
   logic [DVSR_W-1:0] dvs_ff, dvs_in;
   logic [CNTD_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DVSR_W:0]   rem_shift;
   logic [DVSR_W:0]   rem_sub;
   logic              ge;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      ge        = rem_shift >= {1'b0, dvs_ff};
      rem_sub   = ge ? rem_shift - {1'b0, dvs_ff} : rem_shift;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = CNTD_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], ge};
         rem_in = rem_sub[DVSR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTD_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> rtl/core/bfg_ctrl.sv
`default_nettype none

module bfg_ctrl
   import bfg_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic       rsp_ready,
   output logic            rsp_valid,
   input  wire status_type status,
   output cmd_type         cmd
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MUL1 = 5'd1;
   localparam logic [4:0] S_MUL2 = 5'd2;
   localparam logic [4:0] S_DRAW = 5'd3;
   localparam logic [4:0] S_WRAW = 5'd4;
   localparam logic [4:0] S_RAW  = 5'd5;
   localparam logic [4:0] S_WIN  = 5'd6;
   localparam logic [4:0] S_SUM  = 5'd7;
   localparam logic [4:0] S_DAVG = 5'd8;
   localparam logic [4:0] S_WAVG = 5'd9;
   localparam logic [4:0] S_EMA1 = 5'd10;
   localparam logic [4:0] S_EMA2 = 5'd11;
   localparam logic [4:0] S_NUM  = 5'd12;
   localparam logic [4:0] S_DCRV = 5'd13;
   localparam logic [4:0] S_WCRV = 5'd14;
   localparam logic [4:0] S_NORM = 5'd15;
   localparam logic [4:0] S_WALK = 5'd16;
   localparam logic [4:0] S_DINT = 5'd17;
   localparam logic [4:0] S_WINT = 5'd18;
   localparam logic [4:0] S_MAP  = 5'd19;
   localparam logic [4:0] S_FIN  = 5'd20;

   logic [4:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      req_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accum = 1'b1;
               if (status.last_sample) begin
                  state_in = S_MUL1;
               end
            end
         end
         S_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = S_DRAW;
         end
         S_DRAW: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = SEL_RAW;
            state_in      = S_WRAW;
         end
         S_WRAW: begin
            if (status.div_done) begin
               state_in = S_RAW;
            end
         end
         S_RAW: begin
            cmd.take_raw = 1'b1;
            state_in     = S_WIN;
         end
         S_WIN: begin
            cmd.win_write = 1'b1;
            state_in      = S_SUM;
         end
         S_SUM: begin
            cmd.sum_step = 1'b1;
            if (status.sum_last) begin
               state_in = S_DAVG;
            end
         end
         S_DAVG: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = SEL_AVG;
            state_in      = S_WAVG;
         end
         S_WAVG: begin
            if (status.div_done) begin
               state_in = S_EMA1;
            end
         end
         S_EMA1: begin
            cmd.ema_mul = 1'b1;
            state_in    = S_EMA2;
         end
         S_EMA2: begin
            cmd.ema_update = 1'b1;
            state_in       = S_NUM;
         end
         S_NUM: begin
            cmd.take_num = 1'b1;
            state_in     = S_DCRV;
         end
         S_DCRV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = SEL_CURVE;
            state_in      = S_WCRV;
         end
         S_WCRV: begin
            if (status.div_done) begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            cmd.take_norm = 1'b1;
            state_in      = S_WALK;
         end
         S_WALK: begin
            cmd.walk = 1'b1;
            if (status.walk_interp) begin
               state_in = S_DINT;
            end else if (status.walk_done) begin
               state_in = S_FIN;
            end
         end
         S_DINT: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = SEL_INTERP;
            state_in      = S_WINT;
         end
         S_WINT: begin
            if (status.div_done) begin
               state_in = S_MAP;
            end
         end
         S_MAP: begin
            cmd.take_map = 1'b1;
            state_in     = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> rtl/core/bfg_dp.sv
`default_nettype none

module bfg_dp
   import bfg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire logic [SAMPLE_W-1:0]   req_sample_mv,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data,
   output logic [15:0]                rsp_raw_mv,
   output logic [15:0]                rsp_filtered_mv,
   output logic [PCT_W-1:0]           rsp_percent,
   output logic                       rsp_charging,
   output logic                       rsp_low_battery
);

   // configuration
   logic [11:0] div_reg_ff, div_reg_in;
   logic [12:0] scl_reg_ff, scl_reg_in;
   logic [9:0]  ofs_reg_ff, ofs_reg_in;
   logic [11:0] emp_reg_ff, emp_reg_in;
   logic [12:0] full_reg_ff, full_reg_in;
   logic [12:0] thr_reg_ff, thr_reg_in;
   logic [3:0]  cnt_reg_ff, cnt_reg_in;
   logic [3:0]  win_reg_ff, win_reg_in;

   // sample accumulation
   logic [SUM_W-1:0]    ssum_ff, ssum_in;
   logic [SAMPLE_W-1:0] smin_ff, smin_in;
   logic [SAMPLE_W-1:0] smax_ff, smax_in;
   logic [CNT_W-1:0]    sidx_ff, sidx_in;
   logic [SUM_W-1:0]    trim_ff;
   logic [27:0]         p1_ff;
   logic [DIV_W-1:0]    p2_ff;
   logic [15:0]         raw_ff;

   // window
   logic [15:0]          store_ff [WINDOW_MAX];
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [WIN_IDX_W-1:0] pos_ff, pos_in;
   logic [WIN_IDX_W-1:0] sidx2_ff, sidx2_in;
   logic [WSUM_W-1:0]    wsum_ff, wsum_in;

   // filter and mapping
   logic [EMA_W-1:0]  avg_ff;
   logic [30:0]       t90_ff;
   logic [EMA_W-1:0]  ema_ff, ema_in;
   logic              eseed_ff, eseed_in;
   logic [EMA_W-1:0]  num_ff;
   logic              sat_ff;
   logic [NORM_W-1:0] norm_ff;
   logic [SEG_W-1:0]  seg_ff, seg_in;
   logic [NORM_W-1:0] den_ff;
   logic [27:0]       nprod_ff;
   logic [PCT_W-1:0]  plo_ff;
   logic [PCT_W-1:0]  mapped_ff, mapped_in;

   // trend and outputs
   logic [EMA_W-1:0]  tref_ff, tref_in;
   logic              tseed_ff, tseed_in;
   logic [3:0]        rise_ff, rise_in;
   logic [3:0]        fall_ff, fall_in;
   logic [PCT_W-1:0]  held_ff, held_in;
   logic              chg_ff, chg_in;
   logic              low_ff, low_in;
   logic              gvalid_ff, gvalid_in;
   logic [15:0]       rsp_raw_ff, rsp_filt_ff;

   logic [11:0]        div_c;
   logic [12:0]        scl_c;
   logic signed [9:0]  ofs_c;
   logic [11:0]        emp_c;
   logic [12:0]        full_cl, full_c, thr_c;
   logic [3:0]         n_c, win_c, kept;
   logic               clear_all;

   logic [SUM_W-1:0]    nsum;
   logic [SAMPLE_W-1:0] nmin, nmax;
   logic                last;

   logic [DIV_W-1:0]  dv_dividend;
   logic [DVSR_W-1:0] dv_divisor;
   logic              dv_done;
   logic [DIV_W-1:0]  dv_quo;

   logic signed [21:0] rsum;
   logic [15:0]        raw_sat;
   logic [FILL_W-1:0]  fill_inc;
   logic [WIN_IDX_W-1:0] pos_eff, pos_nxt;

   logic [32:0]       ema_mix;
   logic [19:0]       emp_q8;
   logic [12:0]       span;

   logic [NORM_W-1:0] up_v, lo_v, top_v, bot_v;
   logic              w_top, w_bot, w_hit, w_last;
   logic [PCT_W-1:0]  pct_hi, pct_lo;
   logic [8:0]        map_sum;

   logic [EMA_W:0]    ema_e, tref_e;
   logic              tr_up, tr_dn;
   logic              chg_nxt;
   logic [3:0]        rise_nxt, fall_nxt;
   logic [EMA_W:0]    filt_w;

   bfg_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dv_dividend),
      .divisor  (dv_divisor),
      .done     (dv_done),
      .quotient (dv_quo)
   );

   always_comb begin
      div_c = div_reg_ff < 12'd282 ? 12'd282 : (div_reg_ff > 12'd3072 ? 12'd3072 : div_reg_ff);
      scl_c = scl_reg_ff < 13'd3277 ? 13'd3277 : (scl_reg_ff > 13'd4915 ? 13'd4915 : scl_reg_ff);
      ofs_c = $signed(ofs_reg_ff);
      if (ofs_c < -10'sd500) begin
         ofs_c = -10'sd500;
      end else if (ofs_c > 10'sd500) begin
         ofs_c = 10'sd500;
      end
      emp_c = emp_reg_ff < 12'd2500 ? 12'd2500 : (emp_reg_ff > 12'd3800 ? 12'd3800 : emp_reg_ff);
      full_cl = full_reg_ff < 13'd3700 ? 13'd3700 :
                (full_reg_ff > 13'd4350 ? 13'd4350 : full_reg_ff);
      full_c = full_cl <= {1'b0, emp_c} ? {1'b0, emp_c} + 13'd100 : full_cl;
      thr_c = thr_reg_ff < {1'b0, emp_c} ? {1'b0, emp_c} :
              (thr_reg_ff > full_c ? full_c : thr_reg_ff);
      n_c = cnt_reg_ff < 4'd5 ? 4'd5 :
            (cnt_reg_ff > 4'(SAMPLES_MAX) ? 4'(SAMPLES_MAX) : cnt_reg_ff);
      win_c = win_reg_ff < 4'd1 ? 4'd1 :
              (win_reg_ff > 4'(WINDOW_MAX) ? 4'(WINDOW_MAX) : win_reg_ff);
      kept = n_c - 4'd2;
      clear_all = csr_write_enable &&
                  (csr_index == REG_SAMPLES || csr_index == REG_WINDOW);
   end

   always_comb begin
      div_reg_in  = div_reg_ff;
      scl_reg_in  = scl_reg_ff;
      ofs_reg_in  = ofs_reg_ff;
      emp_reg_in  = emp_reg_ff;
      full_reg_in = full_reg_ff;
      thr_reg_in  = thr_reg_ff;
      cnt_reg_in  = cnt_reg_ff;
      win_reg_in  = win_reg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_DIVIDER:   div_reg_in  = csr_write_data[11:0];
            REG_CAL_SCALE: scl_reg_in  = csr_write_data;
            REG_CAL_OFS:   ofs_reg_in  = csr_write_data[9:0];
            REG_EMPTY:     emp_reg_in  = csr_write_data[11:0];
            REG_FULL:      full_reg_in = csr_write_data;
            REG_LOW_THR:   thr_reg_in  = csr_write_data;
            REG_SAMPLES:   cnt_reg_in  = csr_write_data[3:0];
            REG_WINDOW:    win_reg_in  = csr_write_data[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      nsum = ssum_ff + SUM_W'(req_sample_mv);
      nmin = req_sample_mv < smin_ff ? req_sample_mv : smin_ff;
      nmax = req_sample_mv > smax_ff ? req_sample_mv : smax_ff;
      last = ({1'b0, sidx_ff} + 5'd1) >= {1'b0, n_c};
      ssum_in = ssum_ff;
      smin_in = smin_ff;
      smax_in = smax_ff;
      sidx_in = sidx_ff;
      if (clear_all || (cmd.accum && last)) begin
         ssum_in = '0;
         smin_in = '1;
         smax_in = '0;
         sidx_in = '0;
      end else if (cmd.accum) begin
         ssum_in = nsum;
         smin_in = nmin;
         smax_in = nmax;
         sidx_in = sidx_ff + 1'b1;
      end
   end

   always_comb begin
      case (cmd.div_sel)
         SEL_RAW: begin
            dv_dividend = p2_ff + DIV_W'({kept, 19'd0});
            dv_divisor  = DVSR_W'(kept);
         end
         SEL_AVG: begin
            dv_dividend = DIV_W'({wsum_ff, 8'd0}) + DIV_W'(fill_ff >> 1);
            dv_divisor  = DVSR_W'(fill_ff);
         end
         SEL_CURVE: begin
            dv_dividend = DIV_W'(num_ff * 10'd1000);
            dv_divisor  = DVSR_W'(span);
         end
         SEL_INTERP: begin
            dv_dividend = DIV_W'({nprod_ff, 1'b0}) + DIV_W'(den_ff);
            dv_divisor  = DVSR_W'({den_ff, 1'b0});
         end
         default: begin
            dv_dividend = '0;
            dv_divisor  = '0;
         end
      endcase
   end

   always_comb begin
      rsum = $signed({2'b00, dv_quo[39:20]}) + {{12{ofs_c[9]}}, ofs_c};
      if (rsum[21]) begin
         raw_sat = 16'd0;
      end else if (rsum > 22'sd65535) begin
         raw_sat = 16'hFFFF;
      end else begin
         raw_sat = rsum[15:0];
      end
      pos_eff  = {1'b0, pos_ff} >= {1'b0, win_c[WIN_IDX_W-1:0]} && win_c != 4'(WINDOW_MAX)
                 ? '0 : pos_ff;
      if (FILL_W'(pos_ff) >= FILL_W'(win_c)) begin
         pos_eff = '0;
      end
      fill_inc = fill_ff + 1'b1;
      pos_nxt  = (FILL_W'(pos_eff) + 1'b1 == FILL_W'(win_c)) ? '0 : pos_eff + 1'b1;
      fill_in  = fill_ff;
      pos_in   = pos_ff;
      sidx2_in = sidx2_ff;
      wsum_in  = wsum_ff;
      if (clear_all) begin
         fill_in = '0;
         pos_in  = '0;
      end else if (cmd.win_write) begin
         sidx2_in = '0;
         wsum_in  = '0;
         if (fill_ff < FILL_W'(win_c)) begin
            fill_in = fill_inc;
            pos_in  = (fill_inc == FILL_W'(win_c)) ? '0 : pos_eff;
         end else begin
            pos_in = pos_nxt;
         end
      end else if (cmd.sum_step) begin
         wsum_in  = wsum_ff + WSUM_W'(store_ff[sidx2_ff]);
         sidx2_in = sidx2_ff + 1'b1;
      end
   end

   always_comb begin
      ema_mix = 33'(t90_ff) + 33'(ema_ff * 8'd166) + 33'd128;
      ema_in   = ema_ff;
      eseed_in = eseed_ff;
      if (clear_all) begin
         ema_in   = '0;
         eseed_in = 1'b0;
      end else if (cmd.ema_update) begin
         eseed_in = 1'b1;
         ema_in   = eseed_ff ? ema_mix[31:8] : avg_ff;
      end
      emp_q8 = {emp_c, 8'd0};
      span   = full_c - {1'b0, emp_c};
   end

   always_comb begin
      up_v   = {curve_mv(seg_ff), 8'd0};
      lo_v   = {curve_mv(seg_ff + 1'b1), 8'd0};
      top_v  = {curve_mv('0), 8'd0};
      bot_v  = {curve_mv(SEG_W'(CURVE_POINTS - 1)), 8'd0};
      pct_hi = curve_pct(seg_ff);
      pct_lo = curve_pct(seg_ff + 1'b1);
      w_top  = norm_ff >= top_v;
      w_bot  = norm_ff <= bot_v;
      w_hit  = norm_ff <= up_v && norm_ff >= lo_v;
      w_last = seg_ff == SEG_W'(CURVE_POINTS - 2);
      map_sum = {2'b00, plo_ff} + {1'b0, dv_quo[7:0]};
      seg_in    = seg_ff;
      mapped_in = mapped_ff;
      if (cmd.take_norm) begin
         seg_in = '0;
      end else if (cmd.walk) begin
         if (w_top) begin
            mapped_in = 7'd100;
         end else if (w_bot) begin
            mapped_in = '0;
         end else if (w_hit) begin
            mapped_in = pct_lo;
         end else if (w_last) begin
            mapped_in = '0;
         end else begin
            seg_in = seg_ff + 1'b1;
         end
      end else if (cmd.take_map) begin
         mapped_in = map_sum > 9'd100 ? 7'd100 : map_sum[PCT_W-1:0];
      end
   end

   always_comb begin
      ema_e   = {1'b0, ema_ff};
      tref_e  = {1'b0, tref_ff};
      tr_up   = ema_e > tref_e + 25'd1536;
      tr_dn   = ema_e + 25'd1536 < tref_e;
      rise_nxt = rise_ff;
      fall_nxt = fall_ff;
      if (tr_up) begin
         rise_nxt = rise_ff == 4'd15 ? rise_ff : rise_ff + 4'd1;
         fall_nxt = '0;
      end else if (tr_dn) begin
         fall_nxt = fall_ff == 4'd15 ? fall_ff : fall_ff + 4'd1;
         rise_nxt = '0;
      end else begin
         rise_nxt = rise_ff == 4'd0 ? rise_ff : rise_ff - 4'd1;
         fall_nxt = fall_ff == 4'd0 ? fall_ff : fall_ff - 4'd1;
      end
      chg_nxt = chg_ff;
      if (tseed_ff) begin
         if (rise_nxt >= 4'd2) begin
            chg_nxt = 1'b1;
         end else if (fall_nxt >= 4'd2) begin
            chg_nxt = 1'b0;
         end
      end
      filt_w = (ema_e + 25'd128) >> 8;

      tref_in   = tref_ff;
      tseed_in  = tseed_ff;
      rise_in   = rise_ff;
      fall_in   = fall_ff;
      chg_in    = chg_ff;
      held_in   = held_ff;
      low_in    = low_ff;
      gvalid_in = gvalid_ff;
      if (clear_all) begin
         tref_in  = '0;
         tseed_in = 1'b0;
         rise_in  = '0;
         fall_in  = '0;
      end else if (cmd.finish) begin
         tref_in  = ema_ff;
         tseed_in = 1'b1;
         if (tseed_ff) begin
            rise_in = rise_nxt;
            fall_in = fall_nxt;
         end
         chg_in = chg_nxt;
         if (!gvalid_ff) begin
            held_in = mapped_ff;
         end else if (chg_nxt) begin
            if (mapped_ff > held_ff) begin
               held_in = (held_ff + 1'b1 < mapped_ff) ? held_ff + 1'b1 : mapped_ff;
            end else begin
               held_in = mapped_ff;
            end
         end else if (mapped_ff < held_ff) begin
            held_in = mapped_ff;
         end
         gvalid_in = 1'b1;
         if (!low_ff && ema_ff <= EMA_W'({thr_c, 8'd0})) begin
            low_in = 1'b1;
         end else if (low_ff && ema_ff >= EMA_W'({thr_c + 13'd50, 8'd0})) begin
            low_in = 1'b0;
         end
      end
   end

   always_comb begin
      status.last_sample = last;
      status.div_done    = dv_done;
      status.sum_last    = FILL_W'(sidx2_ff) + 1'b1 == fill_ff;
      status.walk_done   = w_top || w_bot || w_hit || w_last;
      status.walk_interp = !w_top && !w_bot && w_hit && up_v > lo_v;
   end

   always_ff @(posedge clock) begin
      if (cmd.accum && last) begin
         trim_ff <= nsum - SUM_W'(nmin) - SUM_W'(nmax);
      end
      if (cmd.mul1) begin
         p1_ff <= trim_ff * div_c;
      end
      if (cmd.mul2) begin
         p2_ff <= DIV_W'(p1_ff * scl_c);
      end
      if (cmd.take_raw) begin
         raw_ff <= raw_sat;
      end
      if (cmd.win_write) begin
         if (fill_ff < FILL_W'(win_c)) begin
            store_ff[fill_ff[WIN_IDX_W-1:0]] <= raw_ff;
         end else begin
            store_ff[pos_eff] <= raw_ff;
         end
      end
      if (cmd.ema_mul) begin
         avg_ff <= dv_quo[EMA_W-1:0];
         t90_ff <= 31'(dv_quo[EMA_W-1:0] * 7'd90);
      end
      if (cmd.take_num) begin
         num_ff <= ema_ff > EMA_W'(emp_q8) ? ema_ff - EMA_W'(emp_q8) : '0;
         sat_ff <= (ema_ff > EMA_W'(emp_q8) ? ema_ff - EMA_W'(emp_q8) : '0) >=
                   EMA_W'({span, 8'd0});
      end
      if (cmd.take_norm) begin
         norm_ff <= NORM_W'(819200) + (sat_ff ? NORM_W'(256000) : NORM_W'(dv_quo[17:0]));
      end
      if (cmd.walk) begin
         den_ff   <= up_v - lo_v;
         nprod_ff <= 28'((norm_ff - lo_v) * (pct_hi - pct_lo));
         plo_ff   <= pct_lo;
      end
      if (cmd.finish) begin
         rsp_raw_ff  <= raw_ff;
         rsp_filt_ff <= filt_w > 25'd65535 ? 16'hFFFF : filt_w[15:0];
      end
      sidx2_ff <= sidx2_in;
      wsum_ff  <= wsum_in;
      seg_ff   <= seg_in;
      mapped_ff <= mapped_in;
      if (reset) begin
         div_reg_ff  <= 12'd512;
         scl_reg_ff  <= 13'd4096;
         ofs_reg_ff  <= '0;
         emp_reg_ff  <= 12'd3300;
         full_reg_ff <= 13'd4200;
         thr_reg_ff  <= 13'd3500;
         cnt_reg_ff  <= 4'd5;
         win_reg_ff  <= 4'd5;
         ssum_ff     <= '0;
         smin_ff     <= '1;
         smax_ff     <= '0;
         sidx_ff     <= '0;
         fill_ff     <= '0;
         pos_ff      <= '0;
         ema_ff      <= '0;
         eseed_ff    <= 1'b0;
         tref_ff     <= '0;
         tseed_ff    <= 1'b0;
         rise_ff     <= '0;
         fall_ff     <= '0;
         held_ff     <= '0;
         chg_ff      <= 1'b0;
         low_ff      <= 1'b0;
         gvalid_ff   <= 1'b0;
      end else begin
         div_reg_ff  <= div_reg_in;
         scl_reg_ff  <= scl_reg_in;
         ofs_reg_ff  <= ofs_reg_in;
         emp_reg_ff  <= emp_reg_in;
         full_reg_ff <= full_reg_in;
         thr_reg_ff  <= thr_reg_in;
         cnt_reg_ff  <= cnt_reg_in;
         win_reg_ff  <= win_reg_in;
         ssum_ff     <= ssum_in;
         smin_ff     <= smin_in;
         smax_ff     <= smax_in;
         sidx_ff     <= sidx_in;
         fill_ff     <= fill_in;
         pos_ff      <= pos_in;
         ema_ff      <= ema_in;
         eseed_ff    <= eseed_in;
         tref_ff     <= tref_in;
         tseed_ff    <= tseed_in;
         rise_ff     <= rise_in;
         fall_ff     <= fall_in;
         held_ff     <= held_in;
         chg_ff      <= chg_in;
         low_ff      <= low_in;
         gvalid_ff   <= gvalid_in;
      end
   end

   assign rsp_raw_mv      = rsp_raw_ff;
   assign rsp_filtered_mv = rsp_filt_ff;
   assign rsp_percent     = held_ff;
   assign rsp_charging    = chg_ff;
   assign rsp_low_battery = low_ff;

endmodule

`default_nettype wire

>>> rtl/core/battery_fuel_gauge.sv
`default_nettype none

// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    sample_mv
// rsp_      out        rsp_valid/rsp_ready    raw_mv filtered_mv percent charging low_battery
// csr_      in         csr_write_enable       csr_index csr_write_data
//
// A sample that does not close a measurement is only accumulated, and the gauge stays ready.
// A closing sample uses the shared 40-step serial divider three or four times
// (the fourth to interpolate) and also runs the window sum and the curve walk.
// Reset is synchronous; configuration returns to its default values.
// Samples are taken while a result waits; a new result stalls until it is taken.

module battery_fuel_gauge
   import bfg_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [SAMPLE_W-1:0]   req_sample_mv,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [15:0]                rsp_raw_mv,
   output logic [15:0]                rsp_filtered_mv,
   output logic [PCT_W-1:0]           rsp_percent,
   output logic                       rsp_charging,
   output logic                       rsp_low_battery,
   input  wire logic                  csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   bfg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   bfg_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_sample_mv    (req_sample_mv),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_raw_mv       (rsp_raw_mv),
      .rsp_filtered_mv  (rsp_filtered_mv),
      .rsp_percent      (rsp_percent),
      .rsp_charging     (rsp_charging),
      .rsp_low_battery  (rsp_low_battery)
   );

endmodule

`default_nettype wire

>>> tb/sv/battery_fuel_gauge_tb.sv
`default_nettype none

module battery_fuel_gauge_tb;
   import bfg_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASES = 12;
   localparam int PHASE_SAMPLES = 148;
   localparam int SETTLE_CYCLES = 300;

   localparam int LIPO_MV [CURVE_POINTS] = '{4200, 4150, 4110, 4080, 4020, 3980, 3950,
      3910, 3870, 3850, 3840, 3820, 3800, 3790, 3770, 3750, 3730, 3710, 3690, 3610, 3300};
   localparam int LIPO_PCT [CURVE_POINTS] = '{100, 95, 90, 85, 80, 75, 70, 65, 60, 55,
      50, 45, 40, 35, 30, 25, 20, 15, 10, 5, 0};

   typedef struct packed {
      logic [15:0]      raw;
      logic [15:0]      filt;
      logic [PCT_W-1:0] pct;
      logic             chg;
      logic             low;
   } gauge_rsp_type;

   typedef struct packed {
      logic                  is_cfg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] val;
      logic                  typed;
      gauge_rsp_type         want;
   } plan_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_sample_mv;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [15:0]           rsp_raw_mv;
   logic [15:0]           rsp_filtered_mv;
   logic [PCT_W-1:0]      rsp_percent;
   logic                  rsp_charging;
   logic                  rsp_low_battery;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   battery_fuel_gauge dut (.*);

   logic [11:0] cfg_div;
   logic [12:0] cfg_scale;
   logic [9:0]  cfg_ofs;
   logic [11:0] cfg_empty;
   logic [12:0] cfg_full;
   logic [12:0] cfg_low;
   logic [3:0]  cfg_count;
   logic [3:0]  cfg_window;

   logic [15:0] acc_sum;
   logic [11:0] acc_min;
   logic [11:0] acc_max;
   int          acc_idx;
   longint      win_store [WINDOW_MAX];
   int          win_fill;
   int          win_pos;
   longint      ema;
   bit          ema_seeded;
   longint      trend_ref;
   bit          trend_seeded;
   int          rise_cnt;
   int          fall_cnt;
   int          held_pct;
   bit          chg_flag;
   bit          low_flag;
   bit          gauge_valid;

   gauge_rsp_type pending_readings [$];
   plan_row_type  plan [$];
   int          mismatches;
   int          cycles;
   bit          quiet;
   int          rsp_stall;
   int          batt_mv;
   int          slope;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic int lipo_percent(longint v, longint emp, longint full);
      longint span, num, off, norm, up, lo, den, n, p;
      span = full - emp;
      num = v > (emp << 8) ? v - (emp << 8) : 0;
      off = num >= (span << 8) ? 256000 : (num * 1000) / span;
      norm = 819200 + off;
      if (norm >= (longint'(LIPO_MV[0]) << 8)) return 100;
      if (norm <= (longint'(LIPO_MV[CURVE_POINTS-1]) << 8)) return 0;
      for (int i = 0; i + 1 < CURVE_POINTS; i++) begin
         up = longint'(LIPO_MV[i]) << 8;
         lo = longint'(LIPO_MV[i+1]) << 8;
         if (norm <= up && norm >= lo) begin
            den = up - lo;
            n = (norm - lo) * (LIPO_PCT[i] - LIPO_PCT[i+1]);
            p = LIPO_PCT[i+1] + (2 * n + den) / (2 * den);
            return p > 100 ? 100 : int'(p);
         end
      end
      return 0;
   endfunction

   task automatic clear_accum();
      acc_sum = '0;
      acc_min = '1;
      acc_max = '0;
      acc_idx = 0;
   endtask

   task automatic clear_filter();
      foreach (win_store[i]) win_store[i] = 0;
      win_fill = 0;
      win_pos = 0;
      ema = 0;
      ema_seeded = 0;
      trend_ref = 0;
      trend_seeded = 0;
      rise_cnt = 0;
      fall_cnt = 0;
   endtask

   task automatic apply_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      case (idx)
         REG_DIVIDER:   cfg_div = val[11:0];
         REG_CAL_SCALE: cfg_scale = val[12:0];
         REG_CAL_OFS:   cfg_ofs = val[9:0];
         REG_EMPTY:     cfg_empty = val[11:0];
         REG_FULL:      cfg_full = val[12:0];
         REG_LOW_THR:   cfg_low = val[12:0];
         REG_SAMPLES: begin
            cfg_count = val[3:0];
            clear_accum();
            clear_filter();
         end
         REG_WINDOW: begin
            cfg_window = val[3:0];
            clear_accum();
            clear_filter();
         end
         default: ;
      endcase
   endtask

   task automatic fold_sample(input logic [SAMPLE_W-1:0] s, output bit done,
                              output gauge_rsp_type r);
      longint n, win, dv, scl, emp, full, thr, ofs, kept, acc, den, rv, avg, mapped, filt;
      done = 0;
      r = '0;
      acc_sum = acc_sum + 16'(s);
      if (s < acc_min) acc_min = s;
      if (s > acc_max) acc_max = s;
      acc_idx++;
      n = clip(cfg_count, 5, SAMPLES_MAX);
      if (acc_idx < n) return;
      win = clip(cfg_window, 1, WINDOW_MAX);
      dv = clip(cfg_div, 282, 3072);
      scl = clip(cfg_scale, 3277, 4915);
      emp = clip(cfg_empty, 2500, 3800);
      full = clip(cfg_full, 3700, 4350);
      ofs = clip(longint'($signed(cfg_ofs)), -500, 500);
      if (full <= emp) full = emp + 100;
      thr = clip(cfg_low, emp, full);
      kept = n - 2;
      acc = longint'(acc_sum) - acc_min - acc_max;
      den = kept << 20;
      rv = clip((acc * dv * scl + den / 2) / den + ofs, 0, 65535);
      clear_accum();

      if (win_pos >= win) win_pos = 0;
      if (win_fill < win) begin
         win_store[win_fill] = rv;
         win_fill++;
         if (win_fill == win) win_pos = 0;
      end else begin
         win_store[win_pos] = rv;
         win_pos = (win_pos + 1) % int'(win);
      end
      avg = 0;
      for (int i = 0; i < win_fill; i++) avg += win_store[i];
      avg = ((avg << 8) + win_fill / 2) / win_fill;
      if (!ema_seeded) begin
         ema = avg;
         ema_seeded = 1;
      end else begin
         ema = ((90 * avg + 166 * ema + 128) >> 8) & 24'hFFFFFF;
      end

      mapped = lipo_percent(ema, emp, full);

      if (!trend_seeded) begin
         trend_ref = ema;
         trend_seeded = 1;
      end else begin
         if (ema > trend_ref + 1536) begin
            if (rise_cnt < 15) rise_cnt++;
            fall_cnt = 0;
         end else if (ema + 1536 < trend_ref) begin
            if (fall_cnt < 15) fall_cnt++;
            rise_cnt = 0;
         end else begin
            if (rise_cnt > 0) rise_cnt--;
            if (fall_cnt > 0) fall_cnt--;
         end
         trend_ref = ema;
         if (rise_cnt >= 2) chg_flag = 1;
         else if (fall_cnt >= 2) chg_flag = 0;
      end

      if (!gauge_valid) held_pct = int'(mapped);
      else if (chg_flag) begin
         if (mapped > held_pct) held_pct = held_pct + 1 < mapped ? held_pct + 1 : int'(mapped);
         else held_pct = int'(mapped);
      end else if (mapped < held_pct) held_pct = int'(mapped);
      gauge_valid = 1;

      if (!low_flag && ema <= (thr << 8)) low_flag = 1;
      else if (low_flag && ema >= ((thr + 50) << 8)) low_flag = 0;

      filt = (ema + 128) >> 8;
      if (filt > 65535) filt = 65535;

      r.raw = 16'(rv);
      r.filt = 16'(filt);
      r.pct = PCT_W'(held_pct);
      r.chg = chg_flag;
      r.low = low_flag;
      done = 1;
   endtask

   task automatic flag_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d, expected %0d at cycle %0d", what, got, want, cycles);
      mismatches++;
   endtask

   task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit typed,
                              input gauge_rsp_type want);
      bit done;
      gauge_rsp_type r;
      req_valid <= 1'b1;
      req_sample_mv <= s;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      fold_sample(s, done, r);
      if (done) pending_readings.push_back(typed ? want : r);
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= val;
      @(posedge clock);
      apply_register(idx, val);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_value(int lo, int hi, int width);
      int v;
      case ($urandom_range(0, 3))
         0:       v = lo;
         1:       v = hi;
         2:       v = int'($urandom_range(hi - lo)) + lo;
         default: v = int'($urandom);
      endcase
      return CSR_DATA_W'(v & ((1 << width) - 1));
   endfunction

   function automatic logic [SAMPLE_W-1:0] next_sample();
      longint pin;
      if ($urandom_range(0, 6) == 0) return SAMPLE_W'($urandom);
      if ($urandom_range(0, 30) == 0) slope = int'($urandom_range(0, 40)) - 20;
      batt_mv = int'(clip(batt_mv + slope, 2400, 4600));
      if (batt_mv == 2400 || batt_mv == 4600) slope = -slope;
      pin = (longint'(batt_mv) << 20) /
            (clip(cfg_div, 282, 3072) * clip(cfg_scale, 3277, 4915));
      pin = pin + int'($urandom_range(0, 24)) - 12;
      return SAMPLE_W'(clip(pin, 0, 4095));
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (quiet) rsp_ready <= 1'b1;
      else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall <= $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   always @(posedge clock) begin
      gauge_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_readings.size() == 0) begin
            flag_mismatch("unexpected result, raw_mv", rsp_raw_mv, 0);
         end else begin
            want = pending_readings.pop_front();
            if (rsp_raw_mv != want.raw) flag_mismatch("raw_mv", rsp_raw_mv, want.raw);
            if (rsp_filtered_mv != want.filt)
               flag_mismatch("filtered_mv", rsp_filtered_mv, want.filt);
            if (rsp_percent != want.pct) flag_mismatch("percent", rsp_percent, want.pct);
            if (rsp_charging != want.chg) flag_mismatch("charging", rsp_charging, want.chg);
            if (rsp_low_battery != want.low)
               flag_mismatch("low_battery", rsp_low_battery, want.low);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_sample_mv = '0;
      rsp_ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      mismatches = 0;
      cycles = 0;
      quiet = 0;
      rsp_stall = 0;
      batt_mv = 3800;
      slope = 3;
      cfg_div = 12'd512;
      cfg_scale = 13'd4096;
      cfg_ofs = '0;
      cfg_empty = 12'd3300;
      cfg_full = 13'd4200;
      cfg_low = 13'd3500;
      cfg_count = 4'd5;
      cfg_window = 4'd5;
      clear_accum();
      clear_filter();
      held_pct = 0;
      chg_flag = 0;
      low_flag = 0;
      gauge_valid = 0;

      repeat (4) plan.push_back('{1'b0, REG_DIVIDER, 13'd2100, 1'b0, '0});
      plan.push_back('{1'b0, REG_DIVIDER, 13'd2100, 1'b1, '{16'd4200, 16'd4200, 7'd100, 1'b0, 1'b0}});
      repeat (5) plan.push_back('{1'b0, REG_DIVIDER, 13'd4095, 1'b0, '0});
      repeat (5) plan.push_back('{1'b0, REG_DIVIDER, 13'd0, 1'b0, '0});
      plan.push_back('{1'b1, REG_CAL_OFS, 13'h20C, 1'b0, '0});
      plan.push_back('{1'b1, REG_DIVIDER, 13'hFFF, 1'b0, '0});
      plan.push_back('{1'b1, REG_CAL_SCALE, 13'd0, 1'b0, '0});
      plan.push_back('{1'b1, REG_EMPTY, 13'hFFF, 1'b0, '0});
      plan.push_back('{1'b1, REG_FULL, 13'd0, 1'b0, '0});
      plan.push_back('{1'b1, REG_LOW_THR, 13'h1FFF, 1'b0, '0});
      plan.push_back('{1'b1, REG_SAMPLES, 13'd9, 1'b0, '0});
      plan.push_back('{1'b1, REG_WINDOW, 13'd1, 1'b0, '0});
      for (int i = 0; i < 9; i++) plan.push_back('{1'b0, REG_DIVIDER, 13'(300 + i * 450), 1'b0, '0});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            drain();
            write_register(plan[i].idx, plan[i].val);
         end else begin
            send_sample(plan[i].val[SAMPLE_W-1:0], plan[i].typed, plan[i].want);
         end
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         drain();
         if (ph == PHASES - 1) quiet = 1;
         write_register(REG_DIVIDER, pick_value(282, 3072, 12));
         write_register(REG_CAL_SCALE, pick_value(3277, 4915, 13));
         write_register(REG_CAL_OFS, pick_value(-500, 500, 10));
         write_register(REG_EMPTY, pick_value(2500, 3800, 12));
         write_register(REG_FULL, pick_value(3700, 4350, 13));
         write_register(REG_LOW_THR, pick_value(2500, 4350, 13));
         write_register(REG_SAMPLES, pick_value(5, 9, 4));
         write_register(REG_WINDOW, pick_value(1, 10, 4));
         for (int k = 0; k < PHASE_SAMPLES; k++) send_sample(next_sample(), 1'b0, '0);
      end

      drain();
      if (mismatches == 0 && pending_readings.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/bfg_pkg.sv
rtl/core/bfg_divider.sv
rtl/core/bfg_ctrl.sv
rtl/core/bfg_dp.sv
rtl/core/battery_fuel_gauge.sv
tb/sv/battery_fuel_gauge_tb.sv
